FILE: rtl/rspa_pkg.sv
// shared types and constants of the rolling sigma power anomaly block
`default_nettype none
package rspa_pkg;

    // configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 12;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SIGMA_MULTIPLE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MEAN_RATIO     = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_SAMPLES    = 2'd2;

    // register widths and reset values
    localparam int SIGMA_BITS = 12;
    localparam int RATIO_BITS = 10;
    localparam int MIN_BITS   = 6;

    localparam logic [SIGMA_BITS-1:0] SIGMA_RESET = 12'd640;
    localparam logic [RATIO_BITS-1:0] RATIO_RESET = 10'd333;
    localparam logic [MIN_BITS-1:0]   MIN_RESET   = 6'd10;

    // square of the sigma multiple
    localparam int SIG2_BITS = 2 * SIGMA_BITS;

    // fixed result widths
    localparam int ENERGY_BITS = 48;
    localparam int COUNT_BITS  = 16;

    // q8 scaling: ratio test shifts by 8, squared deviation test by 16
    localparam int Q8_SHIFT  = 8;
    localparam int LHS_SHIFT = 16;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OLD_SQ,
        ST_NEW_SQ,
        ST_ADD_SQ,
        ST_NX,
        ST_NQ_LO,
        ST_NQ_HI,
        ST_SS,
        ST_DD,
        ST_SIG,
        ST_RHS_LO,
        ST_RHS_HI,
        ST_RATIO,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

FILE: rtl/rspa_in_if.sv
// sample channel: power reading and device on flag
`default_nettype none
interface rspa_in_if #(
    parameter int SAMPLE_BITS = 17
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] power_sample;
    logic                   device_on;

    modport source (output valid, power_sample, device_on, input ready);
    modport sink   (input valid, power_sample, device_on, output ready);
endinterface
`default_nettype wire

FILE: rtl/rspa_out_if.sv
// result channel: flag, counters and window status
`default_nettype none
interface rspa_out_if #(
    parameter int SAMPLE_BITS  = 17,
    parameter int WINDOW_DEPTH = 60
) ();
    localparam int FILL_BITS = $clog2(WINDOW_DEPTH + 1);

    logic                             valid;
    logic                             ready;
    logic                             anomaly;
    logic [rspa_pkg::COUNT_BITS-1:0]  anomaly_total;
    logic [SAMPLE_BITS-1:0]           peak_power;
    logic [rspa_pkg::ENERGY_BITS-1:0] energy_total;
    logic [SAMPLE_BITS+FILL_BITS-1:0] window_sum;
    logic [FILL_BITS-1:0]             window_fill;

    modport source (output valid, anomaly, anomaly_total, peak_power, energy_total,
                    window_sum, window_fill, input ready);
    modport sink   (input valid, anomaly, anomaly_total, peak_power, energy_total,
                    window_sum, window_fill, output ready);
endinterface
`default_nettype wire

FILE: rtl/rspa_window.sv
// sample window memory, one port, registered read
`default_nettype none
module rspa_window #(
    parameter int DEPTH = 60,
    parameter int WIDTH = 17
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

FILE: rtl/rspa_mul.sv
// shared unsigned multiplier with registered product
`default_nettype none
module rspa_mul #(
    parameter int WIDTH = 24
) (
    input  wire logic                 i_clk,
    input  wire logic [WIDTH-1:0]     i_a,
    input  wire logic [WIDTH-1:0]     i_b,
    output      logic [2*WIDTH-1:0]   o_p
);
    localparam int PW = 2 * WIDTH;

    logic [PW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PW'(i_a) * PW'(i_b);
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

FILE: rtl/rolling_sigma_power_anomaly.sv
// top level: rolling window statistics and sigma anomaly test on power readings
//
//  channel  | dir | handshake         | beat contents
//  ---------+-----+-------------------+---------------------------------------------------
//  in_ch    | in  | valid/ready       | power_sample, device_on
//  out_ch   | out | valid/ready       | anomaly, anomaly_total, peak_power, energy_total,
//           |     |                   | window_sum, window_fill
//  i_cfg_*  | in  | write enable only | i_cfg_index selects register, i_cfg_data value
//
//  an input beat keeps the sequencer busy until the next acceptance; the anomaly test
//  states are skipped when it does not run (device off or window not filled enough);
//  the shared multiplier sets the sequence, forming up to eleven products in turn
//  the result sits in an output register, so the next beat is taken while it waits;
//  a finished result holds the sequencer only if the previous result is still untaken
//  synchronous active-low reset clears statistics, counters and registers to defaults;
//  the window memory is not cleared, an entry is used only after it has been written
`default_nettype none
module rolling_sigma_power_anomaly #(
    parameter int WINDOW_DEPTH = 60,
    parameter int SAMPLE_BITS  = 17
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [rspa_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [rspa_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    rspa_in_if.sink                                  in_ch,
    rspa_out_if.source                               out_ch
);
    // widths
    localparam int FB   = $clog2(WINDOW_DEPTH + 1);        // fill count
    localparam int AW   = $clog2(WINDOW_DEPTH);            // window address
    localparam int SW   = SAMPLE_BITS + FB;                // running sum, n*x, deviation
    localparam int QW   = 2 * SAMPLE_BITS + FB;            // running sum of squares
    localparam int S2W  = rspa_pkg::SIG2_BITS;
    localparam int MW   = (SW > S2W) ? SW : S2W;           // multiplier operand
    localparam int PW   = 2 * MW;                          // product
    localparam int VW   = 2 * SW;                          // n*Q, S*S, variance, d*d
    localparam int CW   = PW + S2W;                        // squared test compare
    localparam int RW   = SW + rspa_pkg::RATIO_BITS;       // ratio test compare
    localparam int MINW = (FB > rspa_pkg::MIN_BITS) ? FB : rspa_pkg::MIN_BITS;
    localparam int EW   = rspa_pkg::ENERGY_BITS;
    localparam int KW   = rspa_pkg::COUNT_BITS;

    localparam logic [FB-1:0] FILL_FULL = FB'(WINDOW_DEPTH);
    localparam logic [AW-1:0] ADDR_LAST = AW'(WINDOW_DEPTH - 1);

    // configuration registers
    logic [rspa_pkg::SIGMA_BITS-1:0] r_sigma;
    logic [rspa_pkg::RATIO_BITS-1:0] r_ratio;
    logic [rspa_pkg::MIN_BITS-1:0]   r_min;

    // sequencer
    rspa_pkg::t_state r_state;
    rspa_pkg::t_state n_state;

    // item and window statistics
    logic [SAMPLE_BITS-1:0] r_x;
    logic                   r_on;
    logic                   r_full;
    logic [AW-1:0]          r_wp;
    logic [FB-1:0]          r_fill;
    logic [SW-1:0]          r_sum;
    logic [QW-1:0]          r_sq;
    logic [SAMPLE_BITS-1:0] r_peak;
    logic [EW-1:0]          r_energy;
    logic [KW-1:0]          r_count;
    logic                   r_flag;

    // test intermediates
    logic [SW-1:0]  r_nx;
    logic [SW-1:0]  r_d;
    logic [VW-1:0]  r_v;
    logic [VW-1:0]  r_dd;
    logic [S2W-1:0] r_sig2;
    logic [CW-1:0]  r_acc;

    // result register
    logic                   r_out_valid;
    logic                   r_out_anomaly;
    logic [KW-1:0]          r_out_count;
    logic [SAMPLE_BITS-1:0] r_out_peak;
    logic [EW-1:0]          r_out_energy;
    logic [SW-1:0]          r_out_sum;
    logic [FB-1:0]          r_out_fill;

    // sequencer outputs
    logic          in_ready;
    logic          mem_we;
    logic          mem_re;
    logic          out_load;
    logic [MW-1:0] mul_a;
    logic [MW-1:0] mul_b;

    // datapath wires
    logic [SAMPLE_BITS-1:0] old_sample;
    logic [PW-1:0]          mul_p;
    logic [PW-1:0]          sq_ext;
    logic [PW-1:0]          v_ext;
    logic [VW-1:0]          nq;
    logic [VW-1:0]          ss;
    logic [CW-1:0]          lhs;
    logic [RW-1:0]          nx_scaled;
    logic [EW:0]            energy_sum;
    logic                   test_run;
    logic                   hit;
    logic                   in_accept;

    assign in_accept  = in_ch.valid && in_ready;
    assign sq_ext     = PW'(r_sq);
    assign v_ext      = PW'(r_v);
    assign nq         = r_acc[VW-1:0];
    assign ss         = mul_p[VW-1:0];
    assign lhs        = CW'(r_dd) << rspa_pkg::LHS_SHIFT;
    assign nx_scaled  = RW'(r_nx) << rspa_pkg::Q8_SHIFT;
    assign energy_sum = (EW + 1)'(r_energy) + (EW + 1)'(r_x);
    assign test_run   = r_on && (MINW'(r_fill) >= MINW'(r_min));
    // flagged when variance is nonzero, reading outside k sigma and above ratio times mean
    assign hit        = (r_v != '0) && (lhs > r_acc) && (nx_scaled > mul_p[RW-1:0]);

    rspa_window #(
        .DEPTH (WINDOW_DEPTH),
        .WIDTH (SAMPLE_BITS)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (r_wp),
        .i_wdata (r_x),
        .o_rdata (old_sample)
    );

    rspa_mul #(
        .WIDTH (MW)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma <= rspa_pkg::SIGMA_RESET;
            r_ratio <= rspa_pkg::RATIO_RESET;
            r_min   <= rspa_pkg::MIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rspa_pkg::CFG_SIGMA_MULTIPLE: begin
                    r_sigma <= i_cfg_data[rspa_pkg::SIGMA_BITS-1:0];
                end
                rspa_pkg::CFG_MEAN_RATIO: begin
                    r_ratio <= i_cfg_data[rspa_pkg::RATIO_BITS-1:0];
                end
                rspa_pkg::CFG_MIN_SAMPLES: begin
                    r_min <= i_cfg_data[rspa_pkg::MIN_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rspa_pkg::ST_IDLE: begin
                if (in_ch.valid) begin
                    n_state = rspa_pkg::ST_OLD_SQ;
                end
            end
            rspa_pkg::ST_OLD_SQ:  n_state = rspa_pkg::ST_NEW_SQ;
            rspa_pkg::ST_NEW_SQ:  n_state = rspa_pkg::ST_ADD_SQ;
            rspa_pkg::ST_ADD_SQ: begin
                // off or too few samples: no test, flag holds
                n_state = test_run ? rspa_pkg::ST_NX : rspa_pkg::ST_DONE;
            end
            rspa_pkg::ST_NX:      n_state = rspa_pkg::ST_NQ_LO;
            rspa_pkg::ST_NQ_LO:   n_state = rspa_pkg::ST_NQ_HI;
            rspa_pkg::ST_NQ_HI:   n_state = rspa_pkg::ST_SS;
            rspa_pkg::ST_SS:      n_state = rspa_pkg::ST_DD;
            rspa_pkg::ST_DD:      n_state = rspa_pkg::ST_SIG;
            rspa_pkg::ST_SIG:     n_state = rspa_pkg::ST_RHS_LO;
            rspa_pkg::ST_RHS_LO:  n_state = rspa_pkg::ST_RHS_HI;
            rspa_pkg::ST_RHS_HI:  n_state = rspa_pkg::ST_RATIO;
            rspa_pkg::ST_RATIO:   n_state = rspa_pkg::ST_DONE;
            rspa_pkg::ST_DONE: begin
                if (!r_out_valid || out_ch.ready) begin
                    n_state = rspa_pkg::ST_IDLE;
                end
            end
            default:              n_state = rspa_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake, memory strobes, multiplier operands
    always_comb begin
        in_ready = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        out_load = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        unique case (r_state)
            rspa_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                mem_re   = in_ch.valid;          // fetch entry about to be evicted
            end
            rspa_pkg::ST_OLD_SQ: begin
                mem_we = 1'b1;                   // new sample replaces it
                mul_a  = MW'(old_sample);
                mul_b  = MW'(old_sample);
            end
            rspa_pkg::ST_NEW_SQ: begin
                mul_a = MW'(r_x);
                mul_b = MW'(r_x);
            end
            rspa_pkg::ST_ADD_SQ: begin
                mul_a = MW'(r_fill);             // n*x
                mul_b = MW'(r_x);
            end
            rspa_pkg::ST_NX: begin
                mul_a = MW'(r_fill);             // n*Q low half
                mul_b = sq_ext[MW-1:0];
            end
            rspa_pkg::ST_NQ_LO: begin
                mul_a = MW'(r_fill);             // n*Q high half
                mul_b = sq_ext[PW-1:MW];
            end
            rspa_pkg::ST_NQ_HI: begin
                mul_a = MW'(r_sum);              // S*S
                mul_b = MW'(r_sum);
            end
            rspa_pkg::ST_SS: begin
                mul_a = MW'(r_d);                // deviation squared
                mul_b = MW'(r_d);
            end
            rspa_pkg::ST_DD: begin
                mul_a = MW'(r_sigma);            // k squared
                mul_b = MW'(r_sigma);
            end
            rspa_pkg::ST_SIG: begin
                mul_a = MW'(mul_p[S2W-1:0]);     // k^2 * V low half
                mul_b = v_ext[MW-1:0];
            end
            rspa_pkg::ST_RHS_LO: begin
                mul_a = MW'(r_sig2);             // k^2 * V high half
                mul_b = v_ext[PW-1:MW];
            end
            rspa_pkg::ST_RHS_HI: begin
                mul_a = MW'(r_ratio);            // ratio * S
                mul_b = MW'(r_sum);
            end
            rspa_pkg::ST_RATIO: begin
            end
            rspa_pkg::ST_DONE: begin
                out_load = !r_out_valid || out_ch.ready;
            end
            default: begin
            end
        endcase
    end

    // control state and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rspa_pkg::ST_IDLE;
            r_wp        <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_peak      <= '0;
            r_energy    <= '0;
            r_count     <= '0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_state == rspa_pkg::ST_NEW_SQ) begin
                // mul_p holds the evicted square here
                if (r_full) begin
                    r_sum <= r_sum - SW'(old_sample) + SW'(r_x);
                    r_sq  <= r_sq - mul_p[QW-1:0];
                end else begin
                    r_sum  <= r_sum + SW'(r_x);
                    r_fill <= r_fill + FB'(1);
                end
                r_wp <= (r_wp == ADDR_LAST) ? '0 : r_wp + AW'(1);
            end

            if (r_state == rspa_pkg::ST_ADD_SQ) begin
                r_sq <= r_sq + mul_p[QW-1:0];
                if (r_on) begin
                    if (r_x > r_peak) begin
                        r_peak <= r_x;
                    end
                    r_energy <= energy_sum[EW] ? '1 : energy_sum[EW-1:0];
                end
            end

            if (r_state == rspa_pkg::ST_RATIO) begin
                r_flag <= hit;
                if (hit && (r_count != '1)) begin
                    r_count <= r_count + KW'(1);
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item payload and test intermediates
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_x  <= in_ch.power_sample;
            r_on <= in_ch.device_on;
        end

        unique case (r_state)
            rspa_pkg::ST_OLD_SQ: begin
                r_full <= (r_fill == FILL_FULL);
            end
            rspa_pkg::ST_NX: begin
                r_nx <= mul_p[SW-1:0];
            end
            rspa_pkg::ST_NQ_LO: begin
                r_acc <= CW'(mul_p);
                r_d   <= (r_nx >= r_sum) ? r_nx - r_sum : r_sum - r_nx;
            end
            rspa_pkg::ST_NQ_HI: begin
                r_acc <= r_acc + (CW'(mul_p) << MW);
            end
            rspa_pkg::ST_SS: begin
                // population variance times n squared, clamped at zero
                r_v <= (nq > ss) ? nq - ss : '0;
            end
            rspa_pkg::ST_DD: begin
                r_dd <= mul_p[VW-1:0];
            end
            rspa_pkg::ST_SIG: begin
                r_sig2 <= mul_p[S2W-1:0];
            end
            rspa_pkg::ST_RHS_LO: begin
                r_acc <= CW'(mul_p);
            end
            rspa_pkg::ST_RHS_HI: begin
                r_acc <= r_acc + (CW'(mul_p) << MW);
            end
            default: begin
            end
        endcase

        if (out_load) begin
            r_out_anomaly <= r_flag;
            r_out_count   <= r_count;
            r_out_peak    <= r_peak;
            r_out_energy  <= r_energy;
            r_out_sum     <= r_sum;
            r_out_fill    <= r_fill;
        end
    end

    assign in_ch.ready          = in_ready;
    assign out_ch.valid         = r_out_valid;
    assign out_ch.anomaly       = r_out_anomaly;
    assign out_ch.anomaly_total = r_out_count;
    assign out_ch.peak_power    = r_out_peak;
    assign out_ch.energy_total  = r_out_energy;
    assign out_ch.window_sum    = r_out_sum;
    assign out_ch.window_fill   = r_out_fill;

    // an accepted beat keeps the sequencer busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("input accepted back to back");

    // until the window is full the write pointer tracks the fill count
    a_wp_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != FILL_FULL) |-> (FB'(r_wp) == r_fill))
        else $error("write pointer and fill count disagree");

    // the anomaly count only moves together with a raised flag
    a_count_with_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_count != $past(r_count)) |-> r_flag)
        else $error("anomaly count changed without flag");

    // the peak never decreases between resets
    a_peak_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_peak >= $past(r_peak)))
        else $error("peak decreased");

endmodule
`default_nettype wire

FILE: sim/rolling_sigma_power_anomaly_tb.sv
// testbench of the rolling sigma power anomaly block: predicted results checked beat by beat
`default_nettype none
module rolling_sigma_power_anomaly_tb;

    localparam int SAMPLE_W    = 17;
    localparam int DEPTH       = 60;
    localparam int FILL_W      = $clog2(DEPTH + 1);
    localparam int SUM_W       = SAMPLE_W + FILL_W;
    localparam int STALL_LIMIT = 5000;

    localparam logic [SAMPLE_W-1:0]              SAMPLE_MAX = '1;
    localparam logic [rspa_pkg::ENERGY_BITS-1:0] ENERGY_MAX = '1;
    localparam logic [rspa_pkg::COUNT_BITS-1:0]  COUNT_MAX  = '1;
    // index with no register behind it, a write there must change nothing
    localparam logic [rspa_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

    // one result beat, in port order
    typedef struct packed {
        logic                             anomaly;
        logic [rspa_pkg::COUNT_BITS-1:0]  anomaly_total;
        logic [SAMPLE_W-1:0]              peak_power;
        logic [rspa_pkg::ENERGY_BITS-1:0] energy_total;
        logic [SUM_W-1:0]                 window_sum;
        logic [FILL_W-1:0]                window_fill;
    } t_power_result;

    localparam t_power_result NO_PIN = '0;

    // a directed reading; pinned rows carry their result typed in
    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                on;
        bit                  pinned;
        t_power_result       want;
    } t_reading_row;

    typedef enum {SHAPE_SPIKY, SHAPE_NOISE, SHAPE_FLAT} t_reading_shape;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [rspa_pkg::CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [rspa_pkg::CFG_DATA_BITS-1:0]  i_cfg_data;

    rspa_in_if  #(.SAMPLE_BITS(SAMPLE_W)) in_ch ();
    rspa_out_if #(.SAMPLE_BITS(SAMPLE_W), .WINDOW_DEPTH(DEPTH)) out_ch ();

    rolling_sigma_power_anomaly #(
        .WINDOW_DEPTH(DEPTH),
        .SAMPLE_BITS (SAMPLE_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    // ------------------------------------------------------------------
    // window predictor: own copy of the statistics and the registers
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0]              hist [DEPTH];
    int unsigned                      slot = 0;
    int unsigned                      held = 0;
    logic [63:0]                      win_sum = '0;
    logic [63:0]                      win_sq = '0;
    logic [SAMPLE_W-1:0]              peak = '0;
    logic [rspa_pkg::ENERGY_BITS-1:0] energy = '0;
    logic [rspa_pkg::COUNT_BITS-1:0]  flags = '0;
    logic                             flag = 1'b0;

    logic [rspa_pkg::SIGMA_BITS-1:0]  sigma_q8 = rspa_pkg::SIGMA_RESET;
    logic [rspa_pkg::RATIO_BITS-1:0]  ratio_q8 = rspa_pkg::RATIO_RESET;
    logic [rspa_pkg::MIN_BITS-1:0]    min_fill = rspa_pkg::MIN_RESET;

    // bookkeeping
    t_power_result  pending_results [$];
    t_power_result  head;
    t_power_result  fresh;
    int             err_count = 0;
    int             readings_sent = 0;
    int             results_checked = 0;
    int             flags_seen = 0;
    int             settings_used = 0;
    int             quiet_cycles = 0;
    bit             calm = 1'b0;

    // driven next to the payload so the monitor knows which beat is pinned
    bit             beat_pinned;
    t_power_result  beat_want;

    // reading enters the window, then the on-only updates and the sigma test
    function automatic t_power_result predict_reading(input logic [SAMPLE_W-1:0] x_in,
                                                      input logic on);
        logic [63:0]   x;
        logic [63:0]   old;
        logic [63:0]   n;
        logic [63:0]   nx;
        logic [63:0]   nq;
        logic [63:0]   ss;
        logic [63:0]   v;
        logic [63:0]   d;
        logic [127:0]  lhs;
        logic [127:0]  rhs;
        t_power_result r;
        x = 64'(x_in);
        // full window: the oldest reading leaves first
        if (held >= DEPTH) begin
            old = 64'(hist[slot]);
            win_sum -= old;
            win_sq  -= old * old;
        end else begin
            held++;
        end
        hist[slot] = x_in;
        win_sum += x;
        win_sq  += x * x;
        slot = (slot + 1 == DEPTH) ? 0 : slot + 1;

        if (on) begin
            if (x_in > peak) begin
                peak = x_in;
            end
            if (ENERGY_MAX - energy < rspa_pkg::ENERGY_BITS'(x_in)) begin
                energy = ENERGY_MAX;
            end else begin
                energy = energy + rspa_pkg::ENERGY_BITS'(x_in);
            end
            if (held >= min_fill) begin
                // n^2 * variance against (n*x - sum)^2, all scaled, no root
                n   = 64'(held);
                nx  = n * x;
                nq  = n * win_sq;
                ss  = win_sum * win_sum;
                v   = (nq > ss) ? nq - ss : 64'd0;
                d   = (nx >= win_sum) ? nx - win_sum : win_sum - nx;
                lhs = 128'(d * d) << rspa_pkg::LHS_SHIFT;
                rhs = 128'(sigma_q8) * 128'(sigma_q8) * 128'(v);
                if (v != 0 && lhs > rhs
                    && (nx << rspa_pkg::Q8_SHIFT) > 64'(ratio_q8) * win_sum) begin
                    if (flags != COUNT_MAX) begin
                        flags++;
                    end
                    flag = 1'b1;
                end else begin
                    flag = 1'b0;
                end
            end
        end

        r.anomaly       = flag;
        r.anomaly_total = flags;
        r.peak_power    = peak;
        r.energy_total  = energy;
        r.window_sum    = win_sum[SUM_W-1:0];
        r.window_fill   = FILL_W'(held);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // directed readings, default registers (min fill 10, 2.5 sigma, 1.3x mean)
    // ------------------------------------------------------------------
    t_reading_row directed_rows [20] = '{
        // zero reading while off: enters the window, nothing else moves
        '{17'd0,      1'b0, 1'b1, '{1'b0, 16'd0, 17'd0,  48'd0,  23'd0,  6'd1}},
        // too few readings: peak and energy move, no test yet
        '{17'd10,     1'b1, 1'b1, '{1'b0, 16'd0, 17'd10, 48'd10, 23'd10, 6'd2}},
        '{17'd10,     1'b1, 1'b1, '{1'b0, 16'd0, 17'd10, 48'd20, 23'd20, 6'd3}},
        '{17'd10,     1'b1, 1'b1, '{1'b0, 16'd0, 17'd10, 48'd30, 23'd30, 6'd4}},
        '{17'd10,     1'b1, 1'b0, NO_PIN},
        '{17'd10,     1'b1, 1'b0, NO_PIN},
        '{17'd10,     1'b1, 1'b0, NO_PIN},
        '{17'd10,     1'b1, 1'b0, NO_PIN},
        '{17'd10,     1'b1, 1'b0, NO_PIN},
        // fill reaches the minimum here, first test on a quiet window
        '{17'd10,     1'b1, 1'b0, NO_PIN},
        // full-scale spike on a flat window
        '{17'd131071, 1'b1, 1'b0, NO_PIN},
        // device off right after a flag: flag holds
        '{17'd10,     1'b0, 1'b0, NO_PIN},
        '{17'd10,     1'b1, 1'b0, NO_PIN},
        '{17'd1,      1'b1, 1'b0, NO_PIN},
        // full scale while off: peak and energy stay
        '{17'd131071, 1'b0, 1'b0, NO_PIN},
        '{17'd0,      1'b1, 1'b0, NO_PIN},
        '{17'd65536,  1'b1, 1'b0, NO_PIN},
        '{17'd65535,  1'b1, 1'b0, NO_PIN},
        '{17'h15555,  1'b1, 1'b0, NO_PIN},
        '{17'h0AAAA,  1'b0, 1'b0, NO_PIN}
    };

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones, none at all in calm stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    function automatic int unsigned pick_level();
        case ($urandom_range(0, 2))
            0: begin
                return $urandom_range(1, 200);
            end
            1: begin
                return $urandom_range(1000, 20000);
            end
            default: begin
                return $urandom_range(60000, 130000);
            end
        endcase
    endfunction

    function automatic int unsigned clip_sample(input int unsigned v);
        return (v > SAMPLE_MAX) ? SAMPLE_MAX : v;
    endfunction

    // one reading beat, with an optional gap in front of it;
    // returns on the edge that takes the beat
    task automatic send_reading(input logic [SAMPLE_W-1:0] x, input logic on,
                                input bit pin, input t_power_result want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.power_sample <= x;
        in_ch.device_on    <= on;
        beat_pinned        <= pin;
        beat_want          <= want;
        do @(posedge i_clk); while (!in_ch.ready);
        readings_sent++;
    endtask

    // drop valid and wait until every predicted result has come out
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        // extra wait so the sequencer is back in idle
        repeat (16) @(posedge i_clk);
    endtask

    // write all three registers back to back, the unused index if asked, noise in spare bits
    task automatic program_regs(input logic [rspa_pkg::SIGMA_BITS-1:0] sigma,
                                input logic [rspa_pkg::RATIO_BITS-1:0] ratio,
                                input logic [rspa_pkg::MIN_BITS-1:0] min_val,
                                input bit poke_unused);
        logic [rspa_pkg::CFG_INDEX_BITS-1:0] idx  [4];
        logic [rspa_pkg::CFG_DATA_BITS-1:0]  vals [4];
        int                                  i;
        settle();
        idx[0]  = rspa_pkg::CFG_SIGMA_MULTIPLE;
        idx[1]  = rspa_pkg::CFG_MEAN_RATIO;
        idx[2]  = rspa_pkg::CFG_MIN_SAMPLES;
        idx[3]  = CFG_UNUSED;
        vals[0] = sigma;
        vals[1] = {2'($urandom_range(0, 3)), ratio};
        vals[2] = {6'($urandom_range(0, 63)), min_val};
        vals[3] = 12'($urandom_range(0, 4095));
        for (i = 0; i < (poke_unused ? 4 : 3); i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
            case (idx[i])
                rspa_pkg::CFG_SIGMA_MULTIPLE: begin
                    sigma_q8 = vals[i][rspa_pkg::SIGMA_BITS-1:0];
                end
                rspa_pkg::CFG_MEAN_RATIO: begin
                    ratio_q8 = vals[i][rspa_pkg::RATIO_BITS-1:0];
                end
                rspa_pkg::CFG_MIN_SAMPLES: begin
                    min_fill = vals[i][rspa_pkg::MIN_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // a run of readings: spiky is a steady level with jitter, rare spikes and
    // some noise; flat holds one level so the deviation falls to zero
    task automatic run_phase(input t_reading_shape shape, input int count);
        int unsigned         level;
        int unsigned         jit;
        int                  i;
        int                  r;
        logic [SAMPLE_W-1:0] x;
        logic                on;
        level = pick_level();
        calm  = ($urandom_range(0, 3) == 0);
        for (i = 0; i < count; i++) begin
            case (shape)
                SHAPE_FLAT: begin
                    x  = SAMPLE_W'(level);
                    on = ($urandom_range(0, 15) != 0);
                end
                SHAPE_NOISE: begin
                    x  = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
                    on = 1'($urandom_range(0, 1));
                end
                default: begin
                    on = ($urandom_range(0, 9) != 0);
                    r  = $urandom_range(0, 99);
                    if (r < 6) begin
                        x = SAMPLE_W'(clip_sample(level * $urandom_range(2, 8)
                                                  + $urandom_range(0, 1000)));
                    end else if (r < 10) begin
                        x = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
                    end else begin
                        jit = level / 8 + 1;
                        x   = SAMPLE_W'($urandom_range((level > jit) ? level - jit : 0,
                                                       clip_sample(level + jit)));
                    end
                end
            endcase
            send_reading(x, on, 1'b0, NO_PIN);
            // flip between idling and back-to-back now and then
            if ($urandom_range(0, 49) == 0) begin
                calm = !calm;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        int k;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = rspa_pkg::CFG_SIGMA_MULTIPLE;
        i_cfg_data         = '0;
        in_ch.valid        = 1'b0;
        in_ch.power_sample = '0;
        in_ch.device_on    = 1'b0;
        beat_pinned        = 1'b0;
        beat_want          = NO_PIN;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed walk with reset registers
        for (k = 0; k < $size(directed_rows); k++) begin
            send_reading(directed_rows[k].sample, directed_rows[k].on,
                         directed_rows[k].pinned, directed_rows[k].want);
        end

        // reset registers on a longer spiky run, window wraps here
        run_phase(SHAPE_SPIKY, 150);
        // no sigma and no ratio bar, test from the first reading: flags most on readings
        program_regs(12'd0, 10'd0, 6'd1, 1'b0);
        run_phase(SHAPE_SPIKY, 100);
        // strictest setting, full window needed; poke the empty index too
        program_regs(12'd4095, 10'd1023, 6'd60, 1'b1);
        run_phase(SHAPE_SPIKY, 100);
        // zero minimum: test runs at every fill
        program_regs(12'($urandom_range(0, 1024)), 10'($urandom_range(0, 511)), 6'd0, 1'b0);
        run_phase(SHAPE_NOISE, 80);
        // minimum above the window depth: the test never runs, flag frozen
        program_regs(rspa_pkg::SIGMA_RESET, rspa_pkg::RATIO_RESET,
                     6'($urandom_range(61, 63)), 1'b0);
        run_phase(SHAPE_SPIKY, 60);
        // a few spikes to raise the flag, then a flat run until the deviation is zero
        program_regs(12'($urandom_range(0, 640)), 10'($urandom_range(0, 300)),
                     6'($urandom_range(1, 20)), 1'b0);
        run_phase(SHAPE_SPIKY, 20);
        run_phase(SHAPE_FLAT, 70);
        // random settings
        repeat (4) begin
            program_regs(12'($urandom_range(0, 4095)), 10'($urandom_range(0, 1023)),
                         ($urandom_range(0, 9) < 8) ? 6'($urandom_range(1, 60))
                                                    : 6'($urandom_range(0, 63)), 1'b0);
            run_phase(($urandom_range(0, 3) == 0) ? SHAPE_NOISE : SHAPE_SPIKY, 80);
        end

        settle();
        $display("%0d readings over %0d register settings, %0d results checked",
                 readings_sent, settings_used + 1, results_checked);
        $display("%0d flagged readings predicted, %0d field errors", flags_seen, err_count);
        if (err_count == 0) begin
            $display("rolling_sigma_power_anomaly: match");
        end else begin
            $display("rolling_sigma_power_anomaly: mismatch");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: random back-pressure
    // ------------------------------------------------------------------
    initial begin
        int n;
        out_ch.ready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            n = pick_gap();
            if (n > 0) begin
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // monitors
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR beat %0d %s: got %0d, want %0d", results_checked, what, got, want);
        err_count++;
    endtask

    // every taken reading: advance the predictor, queue what should come out
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            fresh = predict_reading(in_ch.power_sample, in_ch.device_on);
            if (fresh.anomaly) begin
                flags_seen++;
            end
            pending_results.insert(pending_results.size(), beat_pinned ? beat_want : fresh);
        end
    end

    // every taken result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected", 64'(out_ch.window_fill), 0);
            end else begin
                head = pending_results.pop_front();
                if (out_ch.anomaly !== head.anomaly) begin
                    report_mismatch("anomaly", 64'(out_ch.anomaly), 64'(head.anomaly));
                end
                if (out_ch.anomaly_total !== head.anomaly_total) begin
                    report_mismatch("anomaly_total", 64'(out_ch.anomaly_total),
                                    64'(head.anomaly_total));
                end
                if (out_ch.peak_power !== head.peak_power) begin
                    report_mismatch("peak_power", 64'(out_ch.peak_power), 64'(head.peak_power));
                end
                if (out_ch.energy_total !== head.energy_total) begin
                    report_mismatch("energy_total", 64'(out_ch.energy_total),
                                    64'(head.energy_total));
                end
                if (out_ch.window_sum !== head.window_sum) begin
                    report_mismatch("window_sum", 64'(out_ch.window_sum), 64'(head.window_sum));
                end
                if (out_ch.window_fill !== head.window_fill) begin
                    report_mismatch("window_fill", 64'(out_ch.window_fill),
                                    64'(head.window_fill));
                end
                results_checked++;
            end
        end
    end

    // watchdog: too long without any beat or register write
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || i_cfg_we) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending_results.size());
                $display("rolling_sigma_power_anomaly: mismatch");
                $finish;
            end
        end
    end

endmodule
`default_nettype wire
